// ===== rtl/svd_pkg.sv =====
// Package for the stereo volume and downmix block: types, constants and gain lookup.
`timescale 1ns / 1ps
`default_nettype none

package svd_pkg;

    localparam int MAX_ATTEN_STEPS = 50;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 15;
    localparam int PROD_W     = 30;
    localparam int DB_W       = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_RAW_W = 7;
    localparam int STEP_W     = $clog2(MAX_ATTEN_STEPS + 1);

    localparam int GAIN_FULL  = 32767;
    localparam int STEP_COEF  = 29205;
    localparam int ROUND_HALF = 16384;
    localparam int DB_ONE     = 256;
    localparam int DB_HALF    = 128;
    localparam int CLAMP_DB   = 50;
    localparam int DB_SHIFT   = $clog2(DB_ONE);
    localparam int GAIN_SHIFT = 15;

    localparam logic signed [DB_W-1:0] DB_FLOOR = DB_W'(-(CLAMP_DB * DB_ONE));

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_MUTE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_MUTE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MUTE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_VOLUME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_VOLUME   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_VOLUME  = 3'd5;

    typedef logic [GAIN_W-1:0] gain_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mono_sample;
        logic        [SAMPLE_W-1:0] peak_magnitude;
    } out_item_t;

    typedef struct packed {
        gain_t left;
        gain_t right;
    } gain_pair_t;

    // Magnitude of sample times gain, with the sample's sign kept aside
    typedef struct packed {
        logic [PROD_W-1:0] left_mag;
        logic              left_neg;
        logic [PROD_W-1:0] right_mag;
        logic              right_neg;
    } prod_t;

    typedef gain_t gain_table_t [0:MAX_ATTEN_STEPS];

    function automatic gain_table_t build_gain_table();
        gain_table_t tbl;
        int          g;
        g = GAIN_FULL;
        for (int i = 0; i <= MAX_ATTEN_STEPS; i++)
        begin
            tbl[i] = GAIN_W'(g);
            g = (g * STEP_COEF + ROUND_HALF) >>> GAIN_SHIFT;
        end
        return tbl;
    endfunction

    localparam gain_table_t GAIN_TABLE = build_gain_table();

    // Gain of one channel from its mute and the summed volumes
    function automatic gain_t chan_gain(input logic mute,
                                        input logic signed [SAMPLE_W-1:0] master,
                                        input logic signed [SAMPLE_W-1:0] vol);
        logic signed [DB_W-1:0]  db;
        logic        [DB_W-1:0]  atten;
        logic        [DB_W-1:0]  rounded;
        logic [STEP_RAW_W-1:0]   steps;
        db = DB_W'(master) + DB_W'(vol);
        if (mute)
        begin
            return '0;
        end
        if (!db[DB_W-1])
        begin
            return GAIN_W'(GAIN_FULL);
        end
        if (db < DB_FLOOR)
        begin
            db = DB_FLOOR;
        end
        atten   = DB_W'(-db);
        rounded = atten + DB_W'(DB_HALF);
        steps   = STEP_RAW_W'(rounded >> DB_SHIFT);
        if (steps > STEP_RAW_W'(MAX_ATTEN_STEPS))
        begin
            steps = STEP_RAW_W'(MAX_ATTEN_STEPS);
        end
        return GAIN_TABLE[steps[STEP_W-1:0]];
    endfunction

    // Divide a product magnitude by 32767, truncating
    function automatic logic [SAMPLE_W-1:0] div_full(input logic [PROD_W-1:0] x);
        logic [GAIN_W-1:0]   q1;
        logic [SAMPLE_W-1:0] r;
        logic [SAMPLE_W-1:0] q;
        q1 = x[PROD_W-1:GAIN_SHIFT];
        r  = SAMPLE_W'(x[GAIN_SHIFT-1:0]) + SAMPLE_W'(q1);
        q  = SAMPLE_W'(q1);
        if (r >= SAMPLE_W'(2 * GAIN_FULL))
        begin
            q = q + SAMPLE_W'(2);
        end
        else if (r >= SAMPLE_W'(GAIN_FULL))
        begin
            q = q + SAMPLE_W'(1);
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/svd_if.sv =====
// Handshake channels of the block: input frames and output results.
`timescale 1ns / 1ps
`default_nettype none

interface svd_in_if import svd_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface svd_out_if import svd_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== rtl/svd_gain.sv =====
// Configuration registers and registered per-channel gains.
`timescale 1ns / 1ps
`default_nettype none

module svd_gain import svd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output gain_pair_t            gain
);

    logic                       master_mute_reg;
    logic                       left_mute_reg;
    logic                       right_mute_reg;
    logic signed [SAMPLE_W-1:0] master_volume_reg;
    logic signed [SAMPLE_W-1:0] left_volume_reg;
    logic signed [SAMPLE_W-1:0] right_volume_reg;
    gain_pair_t                 gain_reg;
    gain_pair_t                 gain_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_mute_reg   <= 1'b0;
            left_mute_reg     <= 1'b0;
            right_mute_reg    <= 1'b0;
            master_volume_reg <= '0;
            left_volume_reg   <= '0;
            right_volume_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MASTER_MUTE:   master_mute_reg   <= cfg_data[0];
                REG_LEFT_MUTE:     left_mute_reg     <= cfg_data[0];
                REG_RIGHT_MUTE:    right_mute_reg    <= cfg_data[0];
                REG_MASTER_VOLUME: master_volume_reg <= cfg_data[SAMPLE_W-1:0];
                REG_LEFT_VOLUME:   left_volume_reg   <= cfg_data[SAMPLE_W-1:0];
                REG_RIGHT_VOLUME:  right_volume_reg  <= cfg_data[SAMPLE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        gain_next.left  = chan_gain(master_mute_reg | left_mute_reg,
                                    master_volume_reg, left_volume_reg);
        gain_next.right = chan_gain(master_mute_reg | right_mute_reg,
                                    master_volume_reg, right_volume_reg);
    end

    // Recompute every cycle; a write settles here in time for any item accepted after it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg.left  <= GAIN_W'(GAIN_FULL);
            gain_reg.right <= GAIN_W'(GAIN_FULL);
        end
        else
        begin
            gain_reg <= gain_next;
        end
    end

    assign gain = gain_reg;

endmodule

`default_nettype wire

// ===== rtl/svd_scale.sv =====
// Input register and per-channel gain multipliers.
`timescale 1ns / 1ps
`default_nettype none

module svd_scale import svd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    svd_in_if.sink     in_ch,
    input  gain_pair_t gain,
    output logic       prod_valid,
    input  logic       prod_ready,
    output prod_t      prod
);

    logic                s1_valid_reg;
    in_item_t            s1_item_reg;
    logic                s2_valid_reg;
    prod_t               s2_prod_reg;
    prod_t               s2_prod_next;
    logic                s1_ready;
    logic                s2_ready;
    logic [SAMPLE_W-1:0] left_abs;
    logic [SAMPLE_W-1:0] right_abs;
    logic [PROD_W:0]     left_full;
    logic [PROD_W:0]     right_full;

    assign s2_ready    = !s2_valid_reg || prod_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign in_ch.ready = s1_ready;

    always_comb
    begin
        left_abs  = s1_item_reg.left_sample[SAMPLE_W-1]
                  ? SAMPLE_W'(-s1_item_reg.left_sample) : s1_item_reg.left_sample;
        right_abs = s1_item_reg.right_sample[SAMPLE_W-1]
                  ? SAMPLE_W'(-s1_item_reg.right_sample) : s1_item_reg.right_sample;
        left_full  = (PROD_W + 1)'(left_abs) * (PROD_W + 1)'(gain.left);
        right_full = (PROD_W + 1)'(right_abs) * (PROD_W + 1)'(gain.right);
        s2_prod_next.left_mag  = left_full[PROD_W-1:0];
        s2_prod_next.left_neg  = s1_item_reg.left_sample[SAMPLE_W-1];
        s2_prod_next.right_mag = right_full[PROD_W-1:0];
        s2_prod_next.right_neg = s1_item_reg.right_sample[SAMPLE_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && s1_ready)
        begin
            s1_item_reg <= in_ch.item;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_prod_reg <= s2_prod_next;
        end
    end

    assign prod_valid = s2_valid_reg;
    assign prod       = s2_prod_reg;

endmodule

`default_nettype wire

// ===== rtl/svd_mix.sv =====
// Division by full gain, downmix, peak tracking and output register.
`timescale 1ns / 1ps
`default_nettype none

module svd_mix import svd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      prod_valid,
    output logic      prod_ready,
    input  prod_t     prod,
    svd_out_if.source out_ch
);

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] mono_reg;
    logic        [SAMPLE_W-1:0] peak_reg;
    logic signed [SAMPLE_W-1:0] mono_next;
    logic        [SAMPLE_W-1:0] peak_next;
    logic        [SAMPLE_W-1:0] left_q;
    logic        [SAMPLE_W-1:0] right_q;
    logic signed [SAMPLE_W:0]   left_s;
    logic signed [SAMPLE_W:0]   right_s;
    logic signed [SAMPLE_W+1:0] sum;
    logic signed [SAMPLE_W+1:0] halved;
    logic        [SAMPLE_W-1:0] mag;
    logic                       load;

    assign prod_ready = !out_valid_reg || out_ch.ready;
    assign load       = prod_valid && prod_ready;

    always_comb
    begin
        left_q  = div_full(prod.left_mag);
        right_q = div_full(prod.right_mag);
        left_s  = prod.left_neg  ? -(SAMPLE_W + 1)'(left_q)  : (SAMPLE_W + 1)'(left_q);
        right_s = prod.right_neg ? -(SAMPLE_W + 1)'(right_q) : (SAMPLE_W + 1)'(right_q);
        sum     = (SAMPLE_W + 2)'(left_s) + (SAMPLE_W + 2)'(right_s);
        // Bias negative sums so the shift rounds toward zero
        halved    = (sum + (SAMPLE_W + 2)'(sum[SAMPLE_W+1])) >>> 1;
        mono_next = halved[SAMPLE_W-1:0];
        mag       = mono_next[SAMPLE_W-1] ? SAMPLE_W'(-mono_next) : mono_next;
        peak_next = (mag > peak_reg) ? mag : peak_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            peak_reg      <= '0;
        end
        else
        begin
            if (prod_ready)
            begin
                out_valid_reg <= prod_valid;
            end
            if (load)
            begin
                peak_reg <= peak_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mono_reg <= mono_next;
        end
    end

    assign out_ch.valid               = out_valid_reg;
    assign out_ch.item.mono_sample    = mono_reg;
    assign out_ch.item.peak_magnitude = peak_reg;

endmodule

`default_nettype wire

// ===== rtl/stereo_volume_downmix.sv =====
// Top level of the stereo volume control and mono downmix block.
// Each stereo item is scaled per channel by a gain set from the mute and
// volume registers (dB in signed 8.8, steps of about 1 dB down to -50 dB),
// summed, halved toward zero, and returned as one mono sample with the
// running peak magnitude since reset. One item is accepted every cycle
// unless the output stalls. Each item passes through the input register,
// the multiplier register and the output register, in that order.
// Gains are recomputed from the registers each cycle, so a register write
// takes effect for any item accepted after it. Write registers only while no
// item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module stereo_volume_downmix import svd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    svd_in_if.sink                in_ch,
    svd_out_if.source             out_ch
);

    gain_pair_t gain;
    logic       prod_valid;
    logic       prod_ready;
    prod_t      prod;

    svd_gain u_gain
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gain      (gain)
    );

    svd_scale u_scale
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .gain       (gain),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod)
    );

    svd_mix u_mix
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire
